### design/nearest_neighbor_downscaler_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor downscaler
// Shared concurrent checks, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_TOP_DEFINES_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_TOP_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define NND_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nnd: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define NND_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nnd: next-cycle check failed");

`endif

### design/nnd_pkg.sv
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared constants and types of the nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnd_pkg;

    // Fixed field widths.
    localparam int REG_W       = 13;
    localparam int PIX_W       = 8;
    localparam int CFG_INDEX_W = 4;

    // Default parameter values.
    localparam int DEF_MAX_DIMENSION = 4096;
    localparam int DEF_FRACTION_BITS = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_WIDTH  = 4'd0,
        REG_SOURCE_HEIGHT = 4'd1,
        REG_TARGET_WIDTH  = 4'd2,
        REG_TARGET_HEIGHT = 4'd3
    } cfg_reg_t;

    // Status of one iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### design/nnd_div.sv
// ----------------------------------------------------------------------------
// nnd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_neighbor_downscaler_top_defines.svh"

module nnd_div #(
    parameter int DIVIDEND_W = 29,
    parameter int DIVISOR_W  = 13
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output nnd_pkg::div_status_t    status,
    output logic [DIVIDEND_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, work_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so the difference fits.
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            work_next = {work_reg[DIVIDEND_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = work_reg;

    `NND_ASSERT_IMP(a_done_after_busy, done_reg, $past(busy_reg))
    `NND_ASSERT_NXT(a_start_sets_busy, start, busy_reg)

endmodule

### design/nnd_cfg.sv
// ----------------------------------------------------------------------------
// nnd_cfg
// Size registers, clamping and the two step dividers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnd_cfg #(
    parameter  int MAX_DIMENSION = nnd_pkg::DEF_MAX_DIMENSION,
    parameter  int FRACTION_BITS = nnd_pkg::DEF_FRACTION_BITS,
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1),
    localparam int STEP_W        = DIM_W + FRACTION_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nnd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nnd_pkg::REG_W-1:0]      cfg_data,
    output logic                           busy,
    output logic [DIM_W-1:0]               eff_sw,
    output logic [DIM_W-1:0]               eff_sh,
    output logic [DIM_W-1:0]               eff_dw,
    output logic [DIM_W-1:0]               eff_dh,
    output logic [STEP_W-1:0]              h_step,
    output logic [STEP_W-1:0]              v_step
);

    localparam int CMP_W = (nnd_pkg::REG_W > DIM_W) ? nnd_pkg::REG_W : DIM_W;
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRACTION_BITS;

    logic [nnd_pkg::REG_W-1:0] sw_reg, sh_reg, dw_reg, dh_reg;
    logic                      start_reg, start_next;
    logic [STEP_W-1:0]         h_step_reg, v_step_reg;
    logic [DIM_W-1:0]          cl_sw, cl_sh, cl_dw, cl_dh;
    logic [STEP_W-1:0]         h_quot, v_quot;
    nnd_pkg::div_status_t      h_stat, v_stat;
    logic                      wr_en;
    logic                      known_index;

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [nnd_pkg::REG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0) begin
            return DIM_W'(1);
        end else if (ext > CMP_W'(MAX_DIMENSION)) begin
            return DIM_W'(MAX_DIMENSION);
        end
        return DIM_W'(v);
    endfunction

    always_comb begin
        case (cfg_index)
            nnd_pkg::REG_SOURCE_WIDTH,
            nnd_pkg::REG_SOURCE_HEIGHT,
            nnd_pkg::REG_TARGET_WIDTH,
            nnd_pkg::REG_TARGET_HEIGHT: begin
                known_index = 1'b1;
            end
            default: begin
                known_index = 1'b0;
            end
        endcase
    end

    assign cfg_ready  = 1'b1;
    assign wr_en      = cfg_valid && known_index;
    assign start_next = wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg     <= nnd_pkg::REG_W'(1);
            sh_reg     <= nnd_pkg::REG_W'(1);
            dw_reg     <= nnd_pkg::REG_W'(1);
            dh_reg     <= nnd_pkg::REG_W'(1);
            start_reg  <= 1'b0;
            h_step_reg <= STEP_ONE;
            v_step_reg <= STEP_ONE;
        end else begin
            start_reg <= start_next;
            if (wr_en) begin
                case (cfg_index)
                    nnd_pkg::REG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                    nnd_pkg::REG_SOURCE_HEIGHT: sh_reg <= cfg_data;
                    nnd_pkg::REG_TARGET_WIDTH:  dw_reg <= cfg_data;
                    nnd_pkg::REG_TARGET_HEIGHT: dh_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (h_stat.done) begin
                h_step_reg <= h_quot;
            end
            if (v_stat.done) begin
                v_step_reg <= v_quot;
            end
        end
    end

    always_comb begin
        cl_sw  = clamp_dim(sw_reg);
        cl_sh  = clamp_dim(sh_reg);
        cl_dw  = clamp_dim(dw_reg);
        cl_dh  = clamp_dim(dh_reg);
        eff_sw = cl_sw;
        eff_sh = cl_sh;
        // An upscale request falls back to the source size.
        eff_dw = (cl_dw > cl_sw) ? cl_sw : cl_dw;
        eff_dh = (cl_dh > cl_sh) ? cl_sh : cl_dh;
    end

    nnd_div #(
        .DIVIDEND_W (STEP_W),
        .DIVISOR_W  (DIM_W)
    ) u_h_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (STEP_W'(eff_sw) << FRACTION_BITS),
        .divisor  (eff_dw),
        .status   (h_stat),
        .quotient (h_quot)
    );

    nnd_div #(
        .DIVIDEND_W (STEP_W),
        .DIVISOR_W  (DIM_W)
    ) u_v_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (STEP_W'(eff_sh) << FRACTION_BITS),
        .divisor  (eff_dh),
        .status   (v_stat),
        .quotient (v_quot)
    );

    assign busy   = start_reg || h_stat.busy || v_stat.busy || h_stat.done || v_stat.done;
    assign h_step = h_step_reg;
    assign v_step = v_step_reg;

endmodule

### design/nnd_sel.sv
// ----------------------------------------------------------------------------
// nnd_sel
// Input register, raster position tracking, pick logic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_neighbor_downscaler_top_defines.svh"

module nnd_sel #(
    parameter  int MAX_DIMENSION = nnd_pkg::DEF_MAX_DIMENSION,
    parameter  int FRACTION_BITS = nnd_pkg::DEF_FRACTION_BITS,
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1),
    localparam int STEP_W        = DIM_W + FRACTION_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_busy,
    input  logic [DIM_W-1:0]          eff_sw,
    input  logic [DIM_W-1:0]          eff_sh,
    input  logic [DIM_W-1:0]          eff_dw,
    input  logic [DIM_W-1:0]          eff_dh,
    input  logic [STEP_W-1:0]         h_step,
    input  logic [STEP_W-1:0]         v_step,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [nnd_pkg::PIX_W-1:0] s_pixel_in,
    input  logic                      s_frame_start,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [nnd_pkg::PIX_W-1:0] m_pixel_out,
    output logic                      m_row_end,
    output logic                      m_frame_end
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int POS_W = STEP_W + 1;
    localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1) << FRACTION_BITS;
    localparam logic [STEP_W-1:0] STEP_HALF = STEP_ONE >> 1;

    logic                      in_valid_reg, in_valid_next;
    logic [nnd_pkg::PIX_W-1:0] in_pix_reg;
    logic                      in_fs_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [nnd_pkg::PIX_W-1:0] out_pix_reg;
    logic                      out_rend_reg, out_fend_reg;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] x_reg, x_next;
    logic [POS_W-1:0] y_reg, y_next;
    logic [DIM_W-1:0] ocol_reg, ocol_next;
    logic [DIM_W-1:0] orow_reg, orow_next;

    logic [POS_W-1:0] start_x, start_y;
    logic             row_hit, sent, rend, fend;
    logic             advance, s_accept, out_load;

    function automatic logic [POS_W-1:0] start_pos(input logic [STEP_W-1:0] step);
        if (step >= STEP_ONE) begin
            return POS_W'((step >> 1) - STEP_HALF);
        end
        return POS_W'(step >> 1);
    endfunction

    always_comb begin
        start_x   = start_pos(h_step);
        start_y   = start_pos(v_step);
        col_next  = col_reg;
        row_next  = row_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (in_fs_reg) begin
            col_next  = '0;
            row_next  = '0;
            x_next    = start_x;
            y_next    = start_y;
            ocol_next = '0;
            orow_next = '0;
        end

        row_hit = (orow_next < eff_dh) &&
                  (POS_W'(row_next) == (y_next >> FRACTION_BITS));
        sent    = row_hit && (ocol_next < eff_dw) &&
                  (POS_W'(col_next) == (x_next >> FRACTION_BITS));
        rend    = sent && (ocol_next == eff_dw - DIM_W'(1));
        fend    = rend && (orow_next == eff_dh - DIM_W'(1));

        if (sent) begin
            ocol_next = ocol_next + DIM_W'(1);
            x_next    = x_next + POS_W'(h_step);
        end

        // A counter at or past a freshly shrunk size also wraps here.
        if (DIM_W'(col_next) >= eff_sw - DIM_W'(1)) begin
            col_next  = '0;
            ocol_next = '0;
            x_next    = start_x;
            if (row_hit) begin
                orow_next = orow_next + DIM_W'(1);
                y_next    = y_next + POS_W'(v_step);
            end
            if (DIM_W'(row_next) >= eff_sh - DIM_W'(1)) begin
                row_next  = '0;
                x_next    = start_x;
                y_next    = start_y;
                orow_next = '0;
            end else begin
                row_next = row_next + CNT_W'(1);
            end
        end else begin
            col_next = col_next + CNT_W'(1);
        end
    end

    // A beat that picks nothing never waits on the result register.
    assign advance  = in_valid_reg && (!sent || !out_valid_reg || m_ready);
    assign s_ready  = !cfg_busy && (!in_valid_reg || advance);
    assign s_accept = s_valid && s_ready;
    assign out_load = advance && sent;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                x_reg    <= x_next;
                y_reg    <= y_next;
                ocol_reg <= ocol_next;
                orow_reg <= orow_next;
            end
        end
        if (s_accept) begin
            in_pix_reg <= s_pixel_in;
            in_fs_reg  <= s_frame_start;
        end
        if (out_load) begin
            out_pix_reg  <= in_pix_reg;
            out_rend_reg <= rend;
            out_fend_reg <= fend;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pix_reg;
    assign m_row_end   = out_rend_reg;
    assign m_frame_end = out_fend_reg;

    `NND_ASSERT_IMP(a_fend_has_rend, out_valid_reg && out_fend_reg, out_rend_reg)
    `NND_ASSERT_NXT(a_pick_lands, out_load, out_valid_reg)
    `NND_ASSERT_NXT(a_held_beat, in_valid_reg && !advance, in_valid_reg && $stable(in_pix_reg))

endmodule

### design/nearest_neighbor_downscaler_top.sv
// Usage: source pixels enter on the s_ channel (s_valid, s_ready, s_pixel_in,
// s_frame_start) in raster order, with s_frame_start set on the first pixel
// of a frame. Picked pixels leave on the m_ channel with m_row_end on the last
// pixel of an output row and m_frame_end on the last pixel of the frame.
// The four size registers are written through the cfg channel; cfg_ready is
// always high and an index beyond the list is ignored.
// A beat accepted on s_ is held in the input register until it is decided,
// and a picked pixel then moves to the result register and is presented on
// m_. The block takes one beat per cycle for as long as the receiver keeps
// m_ready high and no register write is being processed. The rate is set by
// the position update, one compare and add per axis in a cycle.
// A register write restarts the two bit-serial step dividers, and s_ready
// stays low until both have finished and their new steps are stored.
// After reset all sizes are 1, both steps are 1.0 and counters start at zero.
// When the receiver stalls, the result register holds its beat; one more
// beat waits in the input register, and beats that pick nothing keep moving.
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler_top
// Streaming nearest-neighbor downscaler for 8-bit raster pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_neighbor_downscaler_top #(
    parameter int MAX_DIMENSION = nnd_pkg::DEF_MAX_DIMENSION,
    parameter int FRACTION_BITS = nnd_pkg::DEF_FRACTION_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nnd_pkg::REG_W-1:0]       cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nnd_pkg::PIX_W-1:0]       s_pixel_in,
    input  logic                            s_frame_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nnd_pkg::PIX_W-1:0]       m_pixel_out,
    output logic                            m_row_end,
    output logic                            m_frame_end
);

    // Effective sizes need one bit more than the largest index.
    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int STEP_W = DIM_W + FRACTION_BITS;

    logic              cfg_busy;
    logic [DIM_W-1:0]  eff_sw, eff_sh, eff_dw, eff_dh;
    logic [STEP_W-1:0] h_step, v_step;

    // Size registers, clamping and the 13.16 step division.
    nnd_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (cfg_busy),
        .eff_sw    (eff_sw),
        .eff_sh    (eff_sh),
        .eff_dw    (eff_dw),
        .eff_dh    (eff_dh),
        .h_step    (h_step),
        .v_step    (v_step)
    );

    // Per-pixel selection between the input and result registers.
    nnd_sel #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sel (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_busy      (cfg_busy),
        .eff_sw        (eff_sw),
        .eff_sh        (eff_sh),
        .eff_dw        (eff_dw),
        .eff_dh        (eff_dh),
        .h_step        (h_step),
        .v_step        (v_step),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end)
    );

endmodule

### tb/nearest_neighbor_downscaler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor downscaler regression
// Streams raster pixels through the scaler under random sender bursts and
// receiver stalls. Every accepted beat runs through a bit-accurate model of
// the pixel selection, and every result beat is checked against it in order.
// ----------------------------------------------------------------------------

module nearest_neighbor_downscaler_top_test;
    import nnd_pkg::*;

    localparam int FRAC    = DEF_FRACTION_BITS;
    localparam int POS_W   = REG_W + FRAC;
    localparam int COUNT_W = 12;

    localparam logic [REG_W-1:0] MAX_DIM    = REG_W'(DEF_MAX_DIMENSION);
    localparam logic [POS_W-1:0] ONE_PIXEL  = POS_W'(1) << FRAC;
    localparam logic [POS_W-1:0] HALF_PIXEL = POS_W'(1) << (FRAC - 1);

    // Index codes that map to no register; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNMAPPED_INDEX = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] LAST_UNMAPPED_INDEX  = 4'd15;

    localparam int RANDOM_ITEMS     = 700;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 12;
    localparam int MAX_REPORTS      = 200;
    localparam int TIMEOUT_NS       = 6_000_000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } source_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } picked_beat_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [REG_W-1:0]       cfg_data      = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [PIX_W-1:0]       s_pixel_in    = '0;
    logic                   s_frame_start = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [PIX_W-1:0]       m_pixel_out;
    logic                   m_row_end;
    logic                   m_frame_end;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    nearest_neighbor_downscaler_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end)
    );

    // ------------------------------------------------------------------------
    // Selection model. It holds its own copy of the size registers, the two
    // 13.16 steps, the source and target counters and the next sample
    // positions. The initial values are the state right after reset: all
    // sizes 1, steps 1.0, everything else zero.
    // ------------------------------------------------------------------------
    logic [REG_W-1:0]   src_w_reg = REG_W'(1), src_h_reg = REG_W'(1);
    logic [REG_W-1:0]   dst_w_reg = REG_W'(1), dst_h_reg = REG_W'(1);
    logic [REG_W-1:0]   eff_src_w = REG_W'(1), eff_src_h = REG_W'(1);
    logic [REG_W-1:0]   eff_dst_w = REG_W'(1), eff_dst_h = REG_W'(1);
    logic [POS_W-1:0]   h_step = ONE_PIXEL, v_step = ONE_PIXEL;
    logic [POS_W-1:0]   x_pos = '0, y_pos = '0;
    logic [COUNT_W-1:0] src_col = '0, src_row = '0, dst_col = '0, dst_row = '0;

    source_beat_t pending_pixels[$];   // beats waiting for the driver
    picked_beat_t picked_pixels[$];    // pixels the scaler must still emit

    int beats_queued   = 0;
    int beats_accepted = 0;
    int fail_count     = 0;

    function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] v);
        if (v == '0) return REG_W'(1);
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // The first sample sits at the center of the first target pixel, which is
    // half a source pixel back from step/2 whenever the step is at least one.
    function automatic logic [POS_W-1:0] first_position(input logic [POS_W-1:0] step);
        if (step >= ONE_PIXEL) return (step >> 1) - HALF_PIXEL;
        return step >> 1;
    endfunction

    task automatic recompute_steps();
        eff_src_w = clamp_size(src_w_reg);
        eff_src_h = clamp_size(src_h_reg);
        eff_dst_w = clamp_size(dst_w_reg);
        eff_dst_h = clamp_size(dst_h_reg);
        // Upscaling is not supported, so the target never exceeds the source.
        if (eff_dst_w > eff_src_w) eff_dst_w = eff_src_w;
        if (eff_dst_h > eff_src_h) eff_dst_h = eff_src_h;
        h_step = {eff_src_w, {FRAC{1'b0}}} / eff_dst_w;
        v_step = {eff_src_h, {FRAC{1'b0}}} / eff_dst_h;
    endtask

    task automatic restart_frame_counters();
        src_col = '0;
        src_row = '0;
        dst_col = '0;
        dst_row = '0;
        x_pos   = first_position(h_step);
        y_pos   = first_position(v_step);
    endtask

    // Advances the model by one source pixel and records the pixel if the
    // downscale picks it.
    task automatic select_pixel(input logic [PIX_W-1:0] pix, input logic mark);
        logic         row_hit;
        logic         last_row;
        picked_beat_t pick;
        if (mark) restart_frame_counters();
        row_hit = ({1'b0, dst_row} < eff_dst_h) &&
                  ({1'b0, src_row} == y_pos[POS_W-1:FRAC]);
        if (row_hit && ({1'b0, dst_col} < eff_dst_w) &&
                ({1'b0, src_col} == x_pos[POS_W-1:FRAC])) begin
            pick.pixel     = pix;
            pick.row_end   = ({1'b0, dst_col} + 1'b1 == eff_dst_w);
            pick.frame_end = pick.row_end && ({1'b0, dst_row} + 1'b1 == eff_dst_h);
            picked_pixels.push_back(pick);
            dst_col++;
            x_pos += h_step;
        end
        if ({1'b0, src_col} + 1'b1 >= eff_src_w) begin
            // End of a source row: rewind the columns, step down one target
            // row if this row was sampled, and wrap the frame on its last row.
            last_row = ({1'b0, src_row} + 1'b1 >= eff_src_h);
            src_col  = '0;
            dst_col  = '0;
            x_pos    = first_position(h_step);
            if (row_hit) begin
                dst_row++;
                y_pos += v_step;
            end
            src_row++;
            if (last_row) restart_frame_counters();
        end else begin
            src_col++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Pixels go out in bursts of random length separated by random
    // gaps; a quarter of the gaps are empty so long unbroken streams occur
    // too. A beat is never withdrawn: the next one is only chosen once the
    // current one has been taken.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        source_beat_t next_beat;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                select_pixel(s_pixel_in, s_frame_start);
                beats_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    next_beat = pending_pixels.pop_front();
                    s_pixel_in    <= next_beat.pixel;
                    s_frame_start <= next_beat.frame_start;
                    s_valid       <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It alternates ready runs and short stalls of random length,
    // with an occasional long run without any stall. A toggle of hold_token
    // from the sequence starts a hold-off whose length LONG_HOLD_CYCLES sets,
    // so the block backs up and throttles its input.
    // ------------------------------------------------------------------------
    logic hold_token = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;
    logic rx_on      = 1'b0;
    int   rx_left    = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left--;
            m_ready <= rx_on;
        end else begin
            rx_on = !rx_on;
            if (rx_on)
                rx_left = ($urandom_range(0, 15) == 0) ? 300 : $urandom_range(1, 40);
            else
                rx_left = $urandom_range(1, 6);
            m_ready <= rx_on;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every result beat must match the oldest picked pixel exactly.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        picked_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (picked_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display({"%0t: unexpected beat, expected none, ",
                              "got pixel %0d row_end %0b frame_end %0b"},
                             $time, m_pixel_out, m_row_end, m_frame_end);
            end else begin
                want = picked_pixels.pop_front();
                if (m_pixel_out !== want.pixel)
                    report_mismatch("pixel_out", want.pixel, m_pixel_out);
                if (m_row_end !== want.row_end)
                    report_mismatch("row_end", want.row_end, m_row_end);
                if (m_frame_end !== want.frame_end)
                    report_mismatch("frame_end", want.frame_end, m_frame_end);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers.
    // ------------------------------------------------------------------------
    task automatic queue_pixel(input int unsigned pix, input logic mark);
        source_beat_t beat;
        beat.pixel       = PIX_W'(pix);
        beat.frame_start = mark;
        pending_pixels.push_back(beat);
        beats_queued++;
    endtask

    // Queues count random pixels; with mark set the first one opens a frame.
    task automatic queue_frame(input int count, input logic mark);
        for (int i = 0; i < count; i++)
            queue_pixel($urandom_range(0, 255), mark && (i == 0));
    endtask

    // Waits until every queued beat is taken and every picked pixel has come
    // out, then lets the pipeline settle so that beats which picked nothing
    // are also through before a register is touched.
    task automatic wait_until_idle();
        while (beats_accepted != beats_queued || picked_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One write on the cfg channel. The model takes the new value at the
    // edge where the beat is accepted.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input int unsigned value);
        logic [REG_W-1:0] data;
        data = REG_W'(value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  src_w_reg = data;
            REG_SOURCE_HEIGHT: src_h_reg = data;
            REG_TARGET_WIDTH:  dst_w_reg = data;
            REG_TARGET_HEIGHT: dst_h_reg = data;
            default: ;
        endcase
        if (idx <= REG_TARGET_HEIGHT) recompute_steps();
    endtask

    // A random phase: new sizes (usually small, now and then any 13-bit
    // value), then mostly well-formed frames with random pixels. The rest is
    // truncated frames, frames without a start mark and marks at random.
    task automatic run_random_phase();
        bit wild;
        int kind;
        int frame_len;
        wild = ($urandom_range(0, 9) == 0);
        if (wild) begin
            write_register(REG_SOURCE_WIDTH,  $urandom_range(0, 8191));
            write_register(REG_SOURCE_HEIGHT, $urandom_range(0, 8191));
            write_register(REG_TARGET_WIDTH,  $urandom_range(0, 8191));
            write_register(REG_TARGET_HEIGHT, $urandom_range(0, 8191));
        end else begin
            if ($urandom_range(0, 3) != 0) write_register(REG_SOURCE_WIDTH,  $urandom_range(0, 16));
            if ($urandom_range(0, 3) != 0) write_register(REG_SOURCE_HEIGHT, $urandom_range(0, 10));
            if ($urandom_range(0, 3) != 0) write_register(REG_TARGET_WIDTH,  $urandom_range(0, 18));
            if ($urandom_range(0, 3) != 0) write_register(REG_TARGET_HEIGHT, $urandom_range(0, 12));
        end
        if ($urandom_range(0, 7) == 0)
            write_register(
                CFG_INDEX_W'($urandom_range(FIRST_UNMAPPED_INDEX, LAST_UNMAPPED_INDEX)),
                $urandom_range(0, 8191));
        frame_len = eff_src_w * eff_src_h;
        kind = $urandom_range(0, 9);
        if (wild || frame_len > 400 || kind == 9) begin
            repeat ($urandom_range(20, 80))
                queue_pixel($urandom_range(0, 255), $urandom_range(0, 11) == 0);
        end else if (kind == 8) begin
            // The frame is cut short; the next phase picks up mid-frame.
            queue_frame($urandom_range(1, frame_len), 1'b1);
        end else if (kind == 7) begin
            queue_frame(frame_len * $urandom_range(1, 2), 1'b0);
        end else begin
            repeat ($urandom_range(1, 3)) queue_frame(frame_len, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int random_goal;
        int hold_mark;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Pixels straight out of reset, the first two with no start mark: all
        // sizes are 1, positions are zero, so every pixel is a row and frame end.
        queue_pixel(8'h00, 1'b0);
        queue_pixel(8'hFF, 1'b0);
        queue_pixel(8'hA5, 1'b1);
        wait_until_idle();

        // Writes to unmapped indexes change nothing. The target height asks
        // for an upscale and is held to the source height.
        write_register(FIRST_UNMAPPED_INDEX, '1);
        write_register(LAST_UNMAPPED_INDEX, 13'd3);
        write_register(REG_SOURCE_WIDTH, 13'd4);
        write_register(REG_SOURCE_HEIGHT, 13'd3);
        write_register(REG_TARGET_WIDTH, 13'd2);
        write_register(REG_TARGET_HEIGHT, 13'd6);
        // One full 4x3 frame, then four more pixels with no mark, which must
        // start over as a new frame after the last source pixel.
        queue_pixel(8'hFF, 1'b1);
        repeat (15) queue_pixel($urandom_range(0, 255), 1'b0);
        wait_until_idle();

        // A target width of zero behaves as one.
        write_register(REG_TARGET_WIDTH, '0);
        queue_pixel(8'h00, 1'b1);
        repeat (4) queue_pixel($urandom_range(0, 255), 1'b0);
        wait_until_idle();

        // Widest frame: oversized widths are limited to the maximum and a
        // zero height acts as one, so every pixel of the 4096-pixel row comes
        // out; the first 400 of them are sent. Partway in, the receiver holds
        // off long enough to back up the block.
        write_register(REG_SOURCE_WIDTH, '1);
        write_register(REG_SOURCE_HEIGHT, '0);
        write_register(REG_TARGET_WIDTH, 13'd5000);
        write_register(REG_TARGET_HEIGHT, 13'd3);
        hold_mark = beats_accepted + 64;
        queue_frame(400, 1'b1);
        while (beats_accepted < hold_mark) @(posedge aclk);
        hold_token <= ~hold_token;
        wait_until_idle();

        // Tallest frame, one pixel wide: first every row is kept, then only
        // sixteen rows out of 4096, of which the first two are reached.
        write_register(REG_SOURCE_WIDTH, 13'd1);
        write_register(REG_SOURCE_HEIGHT, '1);
        write_register(REG_TARGET_WIDTH, 13'd1);
        write_register(REG_TARGET_HEIGHT, MAX_DIM);
        queue_frame(100, 1'b1);
        wait_until_idle();
        write_register(REG_TARGET_HEIGHT, 13'd16);
        queue_frame(400, 1'b1);
        wait_until_idle();

        random_goal = beats_queued + RANDOM_ITEMS;
        while (beats_queued < random_goal) begin
            run_random_phase();
            wait_until_idle();
        end

        if (fail_count == 0 && picked_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/nnd_pkg.sv
design/nnd_div.sv
design/nnd_cfg.sv
design/nnd_sel.sv
design/nearest_neighbor_downscaler_top.sv
tb/nearest_neighbor_downscaler_top_test.sv
